@@ rtl/divide_48_by_32_with_remainder_assert.svh @@
// Assertion macros for the 48-by-32 divider.
`ifndef DIVIDE_48_BY_32_WITH_REMAINDER_ASSERT_SVH
`define DIVIDE_48_BY_32_WITH_REMAINDER_ASSERT_SVH

`ifndef SYNTH
`define DV48_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider assertion failed");
`define DV48_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("divider latency assertion failed");
`else
`define DV48_ASSERT_IMPLIES(label, ante, cons)
`define DV48_ASSERT_DELAY(label, ante, n, cons)
`endif

`endif

@@ rtl/dv48_pkg.sv @@
// Package with types and constants for the 48-by-32 divider.
package dv48_pkg;

  localparam int WORD_W             = 32;
  localparam int HIGH_W             = 16;
  localparam int QUOT_W             = 48;
  localparam int DIVIDEND_WIDTH_DEF = 48;
  localparam int BITS_PER_STAGE     = 4;

  typedef struct packed {
    logic [WORD_W-1:0] dividend_low;
    logic [HIGH_W-1:0] dividend_high;
    logic [WORD_W-1:0] divisor;
  } dv48_req_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
    logic              divide_by_zero;
  } dv48_rsp_t;

  typedef struct packed {
    logic valid;
    logic dbz;
  } dv48_ctl_t;

endpackage

@@ rtl/dv48_stage.sv @@
// One pipeline stage of the restoring divider: a few quotient bits per cycle.
module dv48_stage import dv48_pkg::*; #(
  parameter int DQ_W = DIVIDEND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dv48_ctl_t         ctl_in,
  input  logic [WORD_W-1:0] rem_in,
  input  logic [WORD_W-1:0] div_in,
  input  logic [DQ_W-1:0]   dq_in,
  output dv48_ctl_t         ctl_out,
  output logic [WORD_W-1:0] rem_out,
  output logic [WORD_W-1:0] div_out,
  output logic [DQ_W-1:0]   dq_out
);

  logic [WORD_W-1:0] rem_next;
  logic [DQ_W-1:0]   dq_next;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  always_comb begin
    rem_next = rem_in;
    dq_next  = dq_in;
    trial    = '0;
    diff     = '0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      trial   = {rem_next, dq_next[DQ_W-1]};
      dq_next = {dq_next[DQ_W-2:0], 1'b0};
      if (trial >= {1'b0, div_in}) begin
        diff       = trial - {1'b0, div_in};
        rem_next   = diff[WORD_W-1:0];
        dq_next[0] = 1'b1;
      end else begin
        rem_next = trial[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.dbz <= ctl_in.dbz;
    rem_out     <= rem_next;
    div_out     <= div_in;
    dq_out      <= dq_next;
  end

endmodule

@@ rtl/divide_48_by_32_with_remainder.sv @@
// Top level of the pipelined 48-by-32 unsigned divider with remainder.
//
//   port group        dir  handshake         payload
//   start / request   in   start && !busy    dv48_req_t
//   done / result     out  done, one cycle   dv48_rsp_t
//
// One request enters every cycle; busy is high only during reset.
// Each pipeline stage performs four restoring subtract-and-compare steps.
// Reset clears the valid bits of all stages at once; requests in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module divide_48_by_32_with_remainder import dv48_pkg::*; #(
  parameter int DIVIDEND_WIDTH = DIVIDEND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dv48_req_t request,
  output logic      busy,
  output logic      done,
  output dv48_rsp_t result
);

  `include "divide_48_by_32_with_remainder_assert.svh"

  localparam int DIVIDEND_W_EFF = (DIVIDEND_WIDTH < WORD_W + 1) ? WORD_W + 1 :
                                  (DIVIDEND_WIDTH > 64)         ? 64 : DIVIDEND_WIDTH;
  localparam int NUM_STAGES = (DIVIDEND_W_EFF + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int DQ_W       = NUM_STAGES * BITS_PER_STAGE;

  dv48_ctl_t         ctl_s [0:NUM_STAGES];
  logic [WORD_W-1:0] rem_s [0:NUM_STAGES];
  logic [WORD_W-1:0] div_s [0:NUM_STAGES];
  logic [DQ_W-1:0]   dq_s  [0:NUM_STAGES];

  logic              accept;
  logic [63:0]       dividend_full;
  logic [DQ_W+QUOT_W-1:0] quot_ext;

  assign busy   = rst;
  assign accept = start && !busy;

  assign dividend_full = {{(64 - HIGH_W - WORD_W){1'b0}}, request.dividend_high,
                          request.dividend_low};

  always_comb begin
    dq_s[0]                     = '0;
    dq_s[0][DIVIDEND_W_EFF-1:0] = dividend_full[DIVIDEND_W_EFF-1:0];
  end

  assign ctl_s[0].valid = accept;
  assign ctl_s[0].dbz   = (request.divisor == '0);
  assign rem_s[0]       = '0;
  assign div_s[0]       = request.divisor;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    dv48_stage #(
      .DQ_W (DQ_W)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[g]),
      .rem_in  (rem_s[g]),
      .div_in  (div_s[g]),
      .dq_in   (dq_s[g]),
      .ctl_out (ctl_s[g+1]),
      .rem_out (rem_s[g+1]),
      .div_out (div_s[g+1]),
      .dq_out  (dq_s[g+1])
    );
  end

  assign quot_ext = {{QUOT_W{1'b0}}, dq_s[NUM_STAGES]};

  always_comb begin
    done                  = ctl_s[NUM_STAGES].valid;
    result.divide_by_zero = ctl_s[NUM_STAGES].dbz;
    if (ctl_s[NUM_STAGES].dbz) begin
      result.quotient  = '0;
      result.remainder = '0;
    end else begin
      result.quotient  = quot_ext[QUOT_W-1:0];
      result.remainder = rem_s[NUM_STAGES];
    end
  end

  `DV48_ASSERT_IMPLIES(a_rem_below_divisor, done && !result.divide_by_zero, result.remainder < div_s[NUM_STAGES])
  `DV48_ASSERT_DELAY(a_fixed_latency, accept, NUM_STAGES, done)
  `DV48_ASSERT_IMPLIES(a_done_has_request, done, $past(accept, NUM_STAGES))

endmodule

@@ sim/tb.sv @@
// Testbench for the 48-by-32 divider: directed table plus random requests, scoreboarded.
module tb;
  import dv48_pkg::*;

  localparam int N_ROWS      = 20;
  localparam int N_RANDOM    = 1030;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_WAIT  = 24;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    dv48_req_t req;
    logic      typed;
    dv48_rsp_t rsp;
  } div_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  dv48_req_t request;
  logic      busy;
  logic      done;
  dv48_rsp_t result;

  logic      row_typed;
  dv48_rsp_t row_rsp;

  dv48_rsp_t pending_divisions[$];
  dv48_rsp_t owed;
  int        mismatches;
  int        cycle_count;
  div_row_t  div_rows [N_ROWS];

  divide_48_by_32_with_remainder dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic dv48_rsp_t exact_division(dv48_req_t r);
    logic [63:0] num;
    logic [63:0] den;
    dv48_rsp_t   q;
    num = {16'h0, r.dividend_high, r.dividend_low};
    den = {32'h0, r.divisor};
    q = '0;
    if (r.divisor == '0) begin
      q.divide_by_zero = 1'b1;
    end else begin
      q.quotient  = QUOT_W'(num / den);
      q.remainder = WORD_W'(num % den);
    end
    return q;
  endfunction

  function automatic div_row_t row(logic [31:0] lo, logic [15:0] hi, logic [31:0] d,
                                   logic typed, logic [47:0] q, logic [31:0] r,
                                   logic z);
    div_row_t x;
    x.req.dividend_low   = lo;
    x.req.dividend_high  = hi;
    x.req.divisor        = d;
    x.typed              = typed;
    x.rsp.quotient       = q;
    x.rsp.remainder      = r;
    x.rsp.divide_by_zero = z;
    return x;
  endfunction

  function automatic dv48_req_t random_request();
    dv48_req_t r;
    r.dividend_low  = $urandom();
    r.dividend_high = 16'($urandom());
    r.divisor       = $urandom();
    case ($urandom_range(0, 9))
      0: r.divisor = '0;
      1: r.divisor = $urandom_range(1, 255);
      2: r.divisor = 32'h1 << $urandom_range(0, 31);
      3: r.divisor = 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: begin
        if (r.divisor == '0) r.divisor = 32'h1;
        r.dividend_high = '0;
        r.dividend_low  = r.dividend_low % r.divisor;
      end
      5: r.dividend_high = 16'hFFFF;
      6: r.dividend_high = 16'($urandom_range(0, 3));
      default: if (r.divisor == '0) r.divisor = 32'h8000_0000;
    endcase
    return r;
  endfunction

  task automatic send(dv48_req_t r, logic typed, dv48_rsp_t rsp, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    request   <= r;
    row_typed <= typed;
    row_rsp   <= rsp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_divisions.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(bit calm);
    if (calm || $urandom_range(0, 5) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_divisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result q=%h r=%h z=%b",
                   result.quotient, result.remainder, result.divide_by_zero);
      end else begin
        owed = pending_divisions.pop_front();
        if (result.quotient !== owed.quotient || result.remainder !== owed.remainder ||
            result.divide_by_zero !== owed.divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected q=%h r=%h z=%b, got q=%h r=%h z=%b",
                     owed.quotient, owed.remainder, owed.divide_by_zero,
                     result.quotient, result.remainder, result.divide_by_zero);
        end
      end
    end
    if (!rst && start && !busy)
      pending_divisions.push_back(row_typed ? row_rsp : exact_division(request));
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("divide_48_by_32_with_remainder regression: fail");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    row_typed   = 1'b0;
    row_rsp     = '0;
    mismatches  = 0;
    cycle_count = 0;
    div_rows = '{
      row(32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 48'h0,  32'h0,         1'b1),
      row(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 48'h0,  32'h0,         1'b1),
      row(32'h1234_5678, 16'hABCD, 32'h0000_0000, 1'b1, 48'h0,  32'h0,         1'b1),
      row(32'h0000_0000, 16'h0000, 32'h0000_0001, 1'b1, 48'h0,  32'h0,         1'b0),
      row(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0001, 1'b1, 48'hFFFF_FFFF_FFFF,
          32'h0, 1'b0),
      row(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 48'h1_0000, 32'h0000_FFFF, 1'b0),
      row(32'h0000_0001, 16'h0000, 32'hFFFF_FFFF, 1'b1, 48'h0,  32'h1,         1'b0),
      row(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1, 48'h1,  32'h0,         1'b0),
      row(32'h0000_0000, 16'h0001, 32'h0000_0001, 1'b1, 48'h1_0000_0000,
          32'h0, 1'b0),
      row(32'h0000_0000, 16'hFFFF, 32'h8000_0000, 1'b1, 48'h1_FFFE, 32'h0,         1'b0),
      row(32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000, 1'b1, 48'h1_FFFF, 32'h7FFF_FFFF, 1'b0),
      row(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0002, 1'b1, 48'h7FFF_FFFF_FFFF,
          32'h1, 1'b0),
      row(32'h0000_0007, 16'h0000, 32'h0000_0003, 1'b1, 48'h2,  32'h1,         1'b0),
      row(32'hFFFF_FFFE, 16'h0000, 32'hFFFF_FFFF, 1'b1, 48'h0,  32'hFFFF_FFFE, 1'b0),
      row(32'h8000_0000, 16'h0000, 32'h0000_0001, 1'b1, 48'h8000_0000,
          32'h0, 1'b0),
      row(32'hDEAD_BEEF, 16'h1234, 32'h0001_0001, 1'b0, 48'h0,  32'h0,         1'b0),
      row(32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 1'b0, 48'h0,  32'h0,         1'b0),
      row(32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, 48'h0,  32'h0,         1'b0),
      row(32'h0000_0000, 16'h8000, 32'h0000_0003, 1'b0, 48'h0,  32'h0,         1'b0),
      row(32'h9E37_79B9, 16'h7F4A, 32'h7C15_F39D, 1'b0, 48'h0,  32'h0,         1'b0)
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_ROWS; i++)
      send(div_rows[i].req, div_rows[i].typed, div_rows[i].rsp, pick_gap(i < 6));
    drain();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      send(random_request(), 1'b0, '0, pick_gap(i >= N_RANDOM - CALM_TAIL));
    end
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_divisions.size() == 0) begin
      $display("divide_48_by_32_with_remainder regression: pass");
    end else begin
      $display("divide_48_by_32_with_remainder regression: fail");
    end
    $finish;
  end
endmodule
